FILE: hdl/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg
// shared types and codes for the three class priority packet queue
// ----------------------------------------------------------------------------
package tcpq_pkg;

    // defaults for top level parameters
    localparam int DEF_QUEUE_DEPTH = 1024;
    localparam int DEF_TAG_BITS    = 16;

    // configuration registers
    localparam int         LIMIT_W     = 11;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;
    localparam logic       REG_ENABLE  = 1'b0;
    localparam logic       REG_LIMIT   = 1'b1;

    // request commands
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    // response status codes
    localparam logic [2:0] STATUS_ACCEPTED = 3'd0;
    localparam logic [2:0] STATUS_IGNORED  = 3'd1;
    localparam logic [2:0] STATUS_SERVED   = 3'd2;
    localparam logic [2:0] STATUS_EMPTY    = 3'd3;
    localparam logic [2:0] STATUS_FLUSHED  = 3'd4;

    // frame type bytes
    localparam logic [7:0] TYPE_KEYBOARD  = 8'h01;
    localparam logic [7:0] TYPE_MOUSE     = 8'h02;
    localparam logic [7:0] TYPE_ABS_MOUSE = 8'h04;

    // queue classes
    localparam int         NUM_CLS   = 3;
    localparam logic [1:0] CLS_MOUSE = 2'd0;
    localparam logic [1:0] CLS_KEYB  = 2'd1;
    localparam logic [1:0] CLS_AUDIO = 2'd2;

    typedef enum logic
    {
        ST_IDLE,
        ST_RESP
    } state_t;

    typedef struct packed
    {
        logic [1:0]  cmd;
        logic [7:0]  pkt_type;
        logic [15:0] pkt_len;
        logic [15:0] buf_tag;
        logic        link_ready;
    } req_t;

    typedef struct packed
    {
        logic [2:0]         status;
        logic [7:0]         out_type;
        logic [15:0]        out_len;
        logic [15:0]        out_tag;
        logic               dropped;
        logic [7:0]         dropped_type;
        logic [15:0]        dropped_tag;
        logic [LIMIT_W-1:0] queued_total;
    } rsp_t;

    // result bookkeeping between the memory access and the response
    typedef struct packed
    {
        logic [2:0]         status;
        logic               served;
        logic               drop;
        logic               drop_self;
        logic [NUM_CLS-1:0] sel;
        logic [7:0]         self_type;
        logic [15:0]        self_tag;
        logic [LIMIT_W-1:0] total;
    } pend_t;

endpackage

FILE: hdl/three_class_priority_packet_queue.sv
// ----------------------------------------------------------------------------
// three_class_priority_packet_queue
// response: request registers its memory read and result, then the response register; rsp_stall holds it
// req_stall holds a new request until the previous response is loaded (memory access, then response)
// descriptors live in three simple dual port queue memories, one per class
// reset: queues empty, disabled, limit 1024; memory contents stay undefined
// ----------------------------------------------------------------------------
module three_class_priority_packet_queue #(
    parameter int QUEUE_DEPTH = tcpq_pkg::DEF_QUEUE_DEPTH,
    parameter int TAG_BITS    = tcpq_pkg::DEF_TAG_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  tcpq_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output tcpq_pkg::rsp_t rsp_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import tcpq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int STW   = (TAG_BITS < 16) ? TAG_BITS : 16;

    typedef struct packed
    {
        logic [7:0]     pkt_type;
        logic [15:0]    pkt_len;
        logic [STW-1:0] tag;
    } entry_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    state_t             state_reg;
    state_t             state_next;
    logic               enable_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [PTR_W-1:0]   rptr_reg [NUM_CLS];
    logic [PTR_W-1:0]   rptr_next [NUM_CLS];
    logic [PTR_W-1:0]   wptr_reg [NUM_CLS];
    logic [PTR_W-1:0]   wptr_next [NUM_CLS];
    logic [CNT_W-1:0]   cnt_reg [NUM_CLS];
    logic [CNT_W-1:0]   cnt_next [NUM_CLS];
    logic [CNT_W-1:0]   total_reg;
    logic [CNT_W-1:0]   total_next;
    pend_t              pend_reg;
    pend_t              pend_next;
    logic               rsp_valid_reg;
    rsp_t               rsp_data_reg;
    rsp_t               rsp_next;
    entry_t             rd_data_reg [NUM_CLS];

    logic               cfg_we;
    logic               cfg_flush;
    logic               accept;
    logic               rsp_load;
    logic               step_flush;
    logic [NUM_CLS-1:0] cnt_nz;
    logic [NUM_CLS-1:0] wr_sel;
    logic [NUM_CLS-1:0] rd_sel;
    logic [1:0]         cls_in;
    logic [1:0]         victim_cls;
    logic [1:0]         pop_cls;
    logic               push_ok;
    logic               over_limit;
    logic [CMP_W-1:0]   lim_ext;
    logic [CMP_W-1:0]   eff_limit;
    logic [PTR_W-1:0]   rd_addr;
    logic [PTR_W-1:0]   wr_addr;
    entry_t             wr_entry;
    entry_t             rd_entry;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_we    = psel && penable && pwrite;
    assign cfg_flush = cfg_we && (paddr[2] == REG_ENABLE) && enable_reg && !pwdata[0];
    assign prdata    = (paddr[2] == REG_LIMIT) ? 32'(limit_reg) : 32'(enable_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == REG_ENABLE)
            begin
                enable_reg <= pwdata[0];
            end
            else
            begin
                limit_reg <= pwdata[LIMIT_W-1:0];
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state machine outputs
    always_comb
    begin
        req_stall = 1'b1;
        rsp_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: req_stall = 1'b0;
            ST_RESP: rsp_load  = !rsp_valid_reg || !rsp_stall;
            default: req_stall = 1'b1;
        endcase
    end

    assign accept = req_valid && !req_stall;

    // limit and class decode
    always_comb
    begin
        lim_ext = CMP_W'(limit_reg);
        if (lim_ext == '0)
        begin
            eff_limit = CMP_W'(1);
        end
        else if (lim_ext > CMP_W'(QUEUE_DEPTH))
        begin
            eff_limit = CMP_W'(QUEUE_DEPTH);
        end
        else
        begin
            eff_limit = lim_ext;
        end
        over_limit = CMP_W'(total_reg) >= eff_limit;

        for (int g = 0; g < NUM_CLS; g++)
        begin
            cnt_nz[g] = cnt_reg[g] != '0;
        end

        if (req_data.pkt_type == TYPE_MOUSE || req_data.pkt_type == TYPE_ABS_MOUSE)
        begin
            cls_in = CLS_MOUSE;
        end
        else if (req_data.pkt_type == TYPE_KEYBOARD)
        begin
            cls_in = CLS_KEYB;
        end
        else
        begin
            cls_in = CLS_AUDIO;
        end

        // drop order: audio, keyboard, mouse
        if (cnt_nz[CLS_AUDIO] || cls_in == CLS_AUDIO)
        begin
            victim_cls = CLS_AUDIO;
        end
        else if (cnt_nz[CLS_KEYB] || cls_in == CLS_KEYB)
        begin
            victim_cls = CLS_KEYB;
        end
        else
        begin
            victim_cls = CLS_MOUSE;
        end

        // serve order: mouse, keyboard, audio
        if (cnt_nz[CLS_MOUSE])
        begin
            pop_cls = CLS_MOUSE;
        end
        else if (cnt_nz[CLS_KEYB])
        begin
            pop_cls = CLS_KEYB;
        end
        else
        begin
            pop_cls = CLS_AUDIO;
        end

        push_ok = enable_reg && (cls_in != CLS_AUDIO || req_data.link_ready);
    end

    // command decode
    always_comb
    begin
        wr_sel     = '0;
        rd_sel     = '0;
        step_flush = 1'b0;
        pend_next  = '0;
        pend_next.status = STATUS_IGNORED;
        unique case (req_data.cmd)
            CMD_PUSH:
            begin
                if (push_ok)
                begin
                    pend_next.status = STATUS_ACCEPTED;
                    if (over_limit)
                    begin
                        pend_next.drop = 1'b1;
                        if (cnt_nz[victim_cls])
                        begin
                            rd_sel[victim_cls] = 1'b1;
                            wr_sel[cls_in]     = 1'b1;
                        end
                        else
                        begin
                            // new descriptor is the oldest of its class
                            pend_next.drop_self = 1'b1;
                        end
                    end
                    else
                    begin
                        wr_sel[cls_in] = 1'b1;
                    end
                end
            end
            CMD_POP:
            begin
                if (|cnt_nz)
                begin
                    pend_next.status = STATUS_SERVED;
                    pend_next.served = 1'b1;
                    rd_sel[pop_cls]  = 1'b1;
                end
                else
                begin
                    pend_next.status = STATUS_EMPTY;
                end
            end
            CMD_FLUSH:
            begin
                pend_next.status = STATUS_FLUSHED;
                step_flush       = 1'b1;
            end
            default: ;
        endcase
        if (!accept)
        begin
            wr_sel     = '0;
            rd_sel     = '0;
            step_flush = 1'b0;
        end
        pend_next.sel       = rd_sel;
        pend_next.self_type = req_data.pkt_type;
        pend_next.self_tag  = 16'(req_data.buf_tag[STW-1:0]);
        pend_next.total     = LIMIT_W'(total_next);
    end

    // pointer and count update
    always_comb
    begin
        for (int g = 0; g < NUM_CLS; g++)
        begin
            if (cfg_flush || step_flush)
            begin
                rptr_next[g] = '0;
                wptr_next[g] = '0;
                cnt_next[g]  = '0;
            end
            else
            begin
                rptr_next[g] = rd_sel[g] ? ptr_inc(rptr_reg[g]) : rptr_reg[g];
                wptr_next[g] = wr_sel[g] ? ptr_inc(wptr_reg[g]) : wptr_reg[g];
                cnt_next[g]  = cnt_reg[g] + CNT_W'(wr_sel[g]) - CNT_W'(rd_sel[g]);
            end
        end
        if (cfg_flush || step_flush)
        begin
            total_next = '0;
        end
        else
        begin
            total_next = total_reg + CNT_W'(|wr_sel) - CNT_W'(|rd_sel);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            for (int g = 0; g < NUM_CLS; g++)
            begin
                rptr_reg[g] <= '0;
                wptr_reg[g] <= '0;
                cnt_reg[g]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            for (int g = 0; g < NUM_CLS; g++)
            begin
                rptr_reg[g] <= rptr_next[g];
                wptr_reg[g] <= wptr_next[g];
                cnt_reg[g]  <= cnt_next[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_reg <= pend_next;
        end
    end

    // queue memories
    always_comb
    begin
        rd_addr = '0;
        wr_addr = '0;
        for (int g = 0; g < NUM_CLS; g++)
        begin
            if (rd_sel[g])
            begin
                rd_addr = rptr_reg[g];
            end
            if (wr_sel[g])
            begin
                wr_addr = wptr_reg[g];
            end
        end
        wr_entry.pkt_type = req_data.pkt_type;
        wr_entry.pkt_len  = req_data.pkt_len;
        wr_entry.tag      = req_data.buf_tag[STW-1:0];
    end

    for (genvar g = 0; g < NUM_CLS; g++)
    begin : g_store
        entry_t store_mem [QUEUE_DEPTH];

        // read returns the old entry when the same slot is written
        always_ff @(posedge clk)
        begin
            if (rd_sel[g])
            begin
                rd_data_reg[g] <= store_mem[rd_addr];
            end
            if (wr_sel[g])
            begin
                store_mem[wr_addr] <= wr_entry;
            end
        end
    end

    // response
    always_comb
    begin
        rd_entry = '0;
        for (int g = 0; g < NUM_CLS; g++)
        begin
            if (pend_reg.sel[g])
            begin
                rd_entry = rd_data_reg[g];
            end
        end
        rsp_next              = '0;
        rsp_next.status       = pend_reg.status;
        rsp_next.dropped      = pend_reg.drop;
        rsp_next.queued_total = pend_reg.total;
        if (pend_reg.served)
        begin
            rsp_next.out_type = rd_entry.pkt_type;
            rsp_next.out_len  = rd_entry.pkt_len;
            rsp_next.out_tag  = 16'(rd_entry.tag);
        end
        if (pend_reg.drop)
        begin
            if (pend_reg.drop_self)
            begin
                rsp_next.dropped_type = pend_reg.self_type;
                rsp_next.dropped_tag  = pend_reg.self_tag;
            end
            else
            begin
                rsp_next.dropped_type = rd_entry.pkt_type;
                rsp_next.dropped_tag  = 16'(rd_entry.tag);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_data_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

FILE: dv/three_class_priority_packet_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_class_priority_packet_queue_checker
// Watches the request, response and register ports of the queue. It keeps
// its own copy of the three class fifos, the enable bit and the limit. From
// each accepted request it works out the expected response. Each accepted
// response is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module three_class_priority_packet_queue_checker
    import tcpq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  req_t        req_data,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  rsp_t        rsp_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);

    typedef struct packed
    {
        logic [7:0]  ptype;
        logic [15:0] plen;
        logic [15:0] tag;
    } desc_t;

    desc_t              class_fifo[NUM_CLS][$];
    rsp_t               expected_rsp[$];
    logic               enabled;
    logic [LIMIT_W-1:0] limit;

    function automatic logic [1:0] class_of(logic [7:0] ptype);
        if (ptype == TYPE_MOUSE || ptype == TYPE_ABS_MOUSE)
            return CLS_MOUSE;
        if (ptype == TYPE_KEYBOARD)
            return CLS_KEYB;
        return CLS_AUDIO;
    endfunction

    function automatic int held_total();
        return class_fifo[CLS_MOUSE].size() + class_fifo[CLS_KEYB].size()
            + class_fifo[CLS_AUDIO].size();
    endfunction

    function automatic void flush_queues();
        for (int i = 0; i < NUM_CLS; i++)
            class_fifo[i].delete();
    endfunction

    function automatic desc_t take_oldest(int c);
        desc_t d;
        d = class_fifo[c][0];
        class_fifo[c].delete(0);
        return d;
    endfunction

    function automatic void append_desc(int c, desc_t d);
        class_fifo[c] = {class_fifo[c], d};
    endfunction

    function automatic int effective_limit();
        if (limit == 0)
            return 1;
        if (limit > DEF_QUEUE_DEPTH)
            return DEF_QUEUE_DEPTH;
        return int'(limit);
    endfunction

    function automatic rsp_t queue_step(req_t r);
        rsp_t       o;
        desc_t      d;
        desc_t      victim;
        logic [1:0] c;
        logic [1:0] v;
        o = '0;
        o.status = STATUS_IGNORED;
        if (r.cmd == CMD_PUSH)
        begin
            c = class_of(r.pkt_type);
            d.ptype = r.pkt_type;
            d.plen = r.pkt_len;
            d.tag = r.buf_tag;
            if (enabled && (c != CLS_AUDIO || r.link_ready))
            begin
                o.status = STATUS_ACCEPTED;
                if (held_total() + 1 > effective_limit())
                begin
                    if (class_fifo[CLS_AUDIO].size() > 0 || c == CLS_AUDIO)
                        v = CLS_AUDIO;
                    else if (class_fifo[CLS_KEYB].size() > 0 || c == CLS_KEYB)
                        v = CLS_KEYB;
                    else
                        v = CLS_MOUSE;
                    // new descriptor is itself the oldest of its class
                    if (class_fifo[v].size() == 0)
                        victim = d;
                    else
                    begin
                        victim = take_oldest(v);
                        append_desc(c, d);
                    end
                    o.dropped = 1'b1;
                    o.dropped_type = victim.ptype;
                    o.dropped_tag = victim.tag;
                end
                else
                    append_desc(c, d);
            end
        end
        else if (r.cmd == CMD_POP)
        begin
            o.status = STATUS_EMPTY;
            for (int i = 0; i < NUM_CLS; i++)
            begin
                if (o.status == STATUS_EMPTY && class_fifo[i].size() > 0)
                begin
                    d = take_oldest(i);
                    o.status = STATUS_SERVED;
                    o.out_type = d.ptype;
                    o.out_len = d.plen;
                    o.out_tag = d.tag;
                end
            end
        end
        else if (r.cmd == CMD_FLUSH)
        begin
            flush_queues();
            o.status = STATUS_FLUSHED;
        end
        o.queued_total = LIMIT_W'(held_total());
        return o;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            flush_queues();
            expected_rsp.delete();
            enabled = 1'b0;
            limit = LIMIT_RESET;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $error("response with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_rsp[0];
                    expected_rsp.delete(0);
                    check_field("status", want.status, rsp_data.status);
                    check_field("out_type", want.out_type, rsp_data.out_type);
                    check_field("out_len", want.out_len, rsp_data.out_len);
                    check_field("out_tag", want.out_tag, rsp_data.out_tag);
                    check_field("dropped", want.dropped, rsp_data.dropped);
                    check_field("dropped_type", want.dropped_type, rsp_data.dropped_type);
                    check_field("dropped_tag", want.dropped_tag, rsp_data.dropped_tag);
                    check_field("queued_total", want.queued_total, rsp_data.queued_total);
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_ENABLE)
                begin
                    // stopping the block empties every queue
                    if (enabled && !pwdata[0])
                        flush_queues();
                    enabled = pwdata[0];
                end
                else
                    limit = pwdata[LIMIT_W-1:0];
            end
            if (req_valid && !req_stall)
                expected_rsp = {expected_rsp, queue_step(req_data)};
        end
        pending = expected_rsp.size();
    end

endmodule

FILE: dv/three_class_priority_packet_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_class_priority_packet_queue_test
// Drives the queue with a short directed sequence and then with phases of
// random push, pop and flush requests. Between phases the enable bit and the
// limit are rewritten, and the request and response sides idle at varied
// rates. The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module three_class_priority_packet_queue_test;
    import tcpq_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [7:0] TYPE_AUDIO  = 8'h03;
    localparam logic [2:0] ADDR_ENABLE = {REG_ENABLE, 2'b00};
    localparam logic [2:0] ADDR_LIMIT  = {REG_LIMIT, 2'b00};

    localparam int NUM_PHASES = 8;
    localparam int PHASE_ENABLE[NUM_PHASES] = '{1, 1, 1, 0, 1, 1, 1, 1};
    localparam int PHASE_LIMIT[NUM_PHASES]  = '{1024, 3, 1, 0, 0, 2047, 12, 40};
    localparam int PHASE_GAP[NUM_PHASES]    = '{0, 83, 0, 21, 0, 83, 0, 21};
    localparam int PHASE_STALL[NUM_PHASES]  = '{0, 0, 83, 21, 0, 0, 83, 21};
    localparam int PHASE_ITEMS[NUM_PHASES]  = '{220, 220, 200, 120, 200, 220, 250, 250};
    localparam int PHASE_PUSH[NUM_PHASES]   = '{80, 55, 60, 55, 60, 70, 60, 58};

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req_data;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          send_gap_pct;
    int          stall_pct;

    three_class_priority_packet_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    three_class_priority_packet_queue_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_stall = ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial
    begin
        #10_000_000;
        $display("three_class_priority_packet_queue verification failed");
        $finish;
    end

    function automatic req_t make_request(logic [1:0] cmd, logic [7:0] ptype,
                                          logic [15:0] plen, logic [15:0] tag,
                                          logic link);
        req_t r;
        r.cmd = cmd;
        r.pkt_type = ptype;
        r.pkt_len = plen;
        r.buf_tag = tag;
        r.link_ready = link;
        return r;
    endfunction

    function automatic req_t random_request(int push_pct);
        req_t r;
        int   pick;
        r.pkt_len = 16'($urandom);
        r.buf_tag = 16'($urandom);
        r.link_ready = ($urandom_range(0, 99) < 90);
        pick = $urandom_range(0, 99);
        if (pick < 25)
            r.pkt_type = TYPE_MOUSE;
        else if (pick < 35)
            r.pkt_type = TYPE_ABS_MOUSE;
        else if (pick < 55)
            r.pkt_type = TYPE_KEYBOARD;
        else if (pick < 75)
            r.pkt_type = TYPE_AUDIO;
        else
            r.pkt_type = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < push_pct)
            r.cmd = CMD_PUSH;
        else if (pick < 97)
            r.cmd = CMD_POP;
        else if (pick < 99)
            r.cmd = CMD_FLUSH;
        else
            r.cmd = CMD_UNUSED;
        return r;
    endfunction

    // called and returns just after a falling edge
    task automatic send_request(req_t r);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        req_data = r;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
    endtask

    task automatic settle();
        req_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, int value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = 32'(value);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_gap_pct = 0;
        stall_pct = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // disabled after reset
        send_request(make_request(CMD_PUSH, TYPE_MOUSE, 16'h0001, 16'h0001, 1'b1));
        send_request(make_request(CMD_POP, 8'h00, 16'h0000, 16'h0000, 1'b0));
        send_request(make_request(CMD_UNUSED, 8'h00, 16'h0000, 16'h0000, 1'b0));
        settle();
        write_reg(ADDR_ENABLE, 1);
        write_reg(ADDR_LIMIT, 2);

        send_request(make_request(CMD_PUSH, TYPE_KEYBOARD, 16'hFFFF, 16'hFFFF, 1'b0));
        // audio without link
        send_request(make_request(CMD_PUSH, TYPE_AUDIO, 16'h0010, 16'h0020, 1'b0));
        send_request(make_request(CMD_PUSH, TYPE_AUDIO, 16'h0000, 16'h0000, 1'b1));
        // limit reached, oldest audio goes
        send_request(make_request(CMD_PUSH, TYPE_ABS_MOUSE, 16'h1234, 16'h00FF, 1'b1));
        // lone new audio request is dropped at once
        send_request(make_request(CMD_PUSH, 8'hFF, 16'h8000, 16'hAAAA, 1'b1));
        send_request(make_request(CMD_PUSH, TYPE_MOUSE, 16'h0001, 16'h0001, 1'b0));
        send_request(make_request(CMD_PUSH, TYPE_KEYBOARD, 16'h5555, 16'h5555, 1'b1));
        send_request(make_request(CMD_PUSH, TYPE_MOUSE, 16'h7FFF, 16'h8001, 1'b1));
        repeat (4) send_request(make_request(CMD_POP, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send_request(make_request(CMD_PUSH, 8'h00, 16'h0000, 16'h0000, 1'b1));
        send_request(make_request(CMD_FLUSH, 8'h00, 16'h0000, 16'h0000, 1'b0));
        send_request(make_request(CMD_POP, 8'h00, 16'h0000, 16'h0000, 1'b0));
        send_request(make_request(CMD_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            write_reg(ADDR_ENABLE, PHASE_ENABLE[p]);
            write_reg(ADDR_LIMIT, PHASE_LIMIT[p]);
            send_gap_pct = PHASE_GAP[p];
            stall_pct = PHASE_STALL[p];
            repeat (PHASE_ITEMS[p]) send_request(random_request(PHASE_PUSH[p]));
        end

        settle();
        stall_pct = 0;
        repeat (6) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("three_class_priority_packet_queue verification clean");
        else
            $display("three_class_priority_packet_queue verification failed");
        $finish;
    end

endmodule

FILE: sim.f
hdl/tcpq_pkg.sv
hdl/three_class_priority_packet_queue.sv
dv/three_class_priority_packet_queue_checker.sv
dv/three_class_priority_packet_queue_test.sv
